// ===== rtl/hit_pkg.sv =====
package hit_pkg;

    // Grey levels and histogram geometry.
    localparam int unsigned LEVELS      = 256;
    localparam int unsigned LEVEL_W     = 8;
    localparam int unsigned BIN_W       = 21;
    localparam logic [BIN_W-1:0] BIN_MAX = {BIN_W{1'b1}};

    // Sums over all bins: 256 bins of 21 bits, weighted by an 8-bit level.
    localparam int unsigned CNT_W       = BIN_W + LEVEL_W;
    localparam int unsigned SUM_W       = BIN_W + 2 * LEVEL_W;

    // Defaults of the top-level parameters.
    localparam int unsigned DEF_MAX_PASSES = 256;

    // Request from the sequencer to the shared divider.
    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } div_req_t;

    // Answer of the shared divider.
    typedef struct packed {
        logic               done;
        logic [LEVEL_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== rtl/hit_ram.sv =====
module hit_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/hit_div.sv =====
module hit_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  hit_pkg::div_req_t req,
    output hit_pkg::div_rsp_t rsp
);
    import hit_pkg::*;

    localparam int unsigned STEP_W = $clog2(LEVEL_W);

    // The quotient is a mean grey level and so fits in eight bits; the
    // restoring divider therefore needs only eight steps.
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [SUM_W-1:0]   rem_reg, rem_next;
    logic [CNT_W-1:0]   dvs_reg, dvs_next;
    logic [LEVEL_W-1:0] quo_reg, quo_next;
    logic [SUM_W:0]     trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        trial     = {1'b0, rem_reg} -
                    ({{(SUM_W+1-CNT_W){1'b0}}, dvs_reg} << step_reg);
        if (req.start) begin
            busy_next = 1'b1;
            step_next = STEP_W'(LEVEL_W - 1);
            rem_next  = req.dividend;
            dvs_next  = req.divisor;
            quo_next  = '0;
        end else if (busy_reg) begin
            // One quotient bit a cycle, most significant first.
            if (!trial[SUM_W]) begin
                rem_next = trial[SUM_W-1:0];
            end
            quo_next = {quo_reg[LEVEL_W-2:0], ~trial[SUM_W]};
            if (step_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        step_reg <= step_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        quo_reg  <= quo_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== rtl/histogram_isodata_threshold.sv =====
// Channel | Direction | tdata (low bit up)    | tuser | tlast
// s_      | in        | pixel[7:0]            | -     | last
// m_      | out       | threshold[7:0]        | converged | -
//
// Pixels that are not last are taken back to back; the bin update is a
// read-modify-write of the histogram RAM, with a forwarding register for
// repeated levels. A last pixel starts a scan for the occupied range. If
// only one level is occupied, it is the result; otherwise each pass sums
// the histogram, then runs the dark and the bright division in the shared
// divider and checks stability. Up to MAX_PASSES passes run, and a sweep
// that clears all 256 bins follows the result and also runs after reset,
// while s_tready is low. The result waits in an output register while the
// next frame is taken; a last pixel is held off while it still waits.
module histogram_isodata_threshold #(
    parameter int unsigned MAX_PASSES = hit_pkg::DEF_MAX_PASSES
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // pixel[7:0]
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // threshold[7:0]
    output logic       m_tuser    // converged
);
    import hit_pkg::*;

    localparam int unsigned PASS_W = $clog2(MAX_PASSES + 1);

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_SCAN  = 4'd2;
    localparam logic [3:0] ST_SUM   = 4'd3;
    localparam logic [3:0] ST_DIVD  = 4'd4;
    localparam logic [3:0] ST_WAITD = 4'd5;
    localparam logic [3:0] ST_WAITB = 4'd6;
    localparam logic [3:0] ST_NEXT  = 4'd7;
    localparam logic [3:0] ST_OUT   = 4'd8;
    localparam logic [3:0] ST_FLUSH = 4'd9;

    logic [3:0]          state_reg, state_next;
    logic [LEVEL_W:0]    idx_reg, idx_next;
    logic [LEVEL_W-1:0]  lvl_reg, lvl_next;
    logic [LEVEL_W-1:0]  low_reg, low_next;
    logic [LEVEL_W-1:0]  high_reg, high_next;
    logic                seen_reg, seen_next;
    logic                stable_reg, stable_next;
    logic [LEVEL_W-1:0]  dmean_reg, dmean_next;
    logic [PASS_W-1:0]   pass_reg, pass_next;
    logic [SUM_W-1:0]    dsum_reg, dsum_next, bsum_reg, bsum_next;
    logic [CNT_W-1:0]    dcnt_reg, dcnt_next, bcnt_reg, bcnt_next;
    logic                rd_ok_reg, rd_ok_next;
    logic [LEVEL_W-1:0]  rd_lvl_reg, rd_lvl_next;
    logic                mvalid_reg, mvalid_next;
    logic [LEVEL_W-1:0]  mthr_reg, mthr_next;
    logic                mconv_reg, mconv_next;
    // Pixel update pipeline: the bin is read when the pixel is taken, then upd_reg marks the increment to write back.
    logic                upd_reg, upd_next;
    logic [LEVEL_W-1:0]  upd_lvl_reg;
    logic [BIN_W-1:0]    fwd_val_reg;
    logic                fwd_ok_reg;
    logic [LEVEL_W-1:0]  fwd_lvl_reg;

    logic                wr_en;
    logic [LEVEL_W-1:0]  wr_addr, rd_addr;
    logic [BIN_W-1:0]    wr_data, rd_data, bin_now, bin_inc;
    logic [SUM_W-1:0]    prod;
    div_req_t            dreq;
    div_rsp_t            drsp;
    logic                take;

    hit_ram #(.WIDTH(BIN_W), .DEPTH(LEVELS)) u_ram (
        .aclk(aclk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd_data)
    );

    hit_div u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    assign take     = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE) && !(mvalid_reg && !m_tready && s_tlast);
    // Forward a bin written in the previous cycle.
    assign bin_now  = (fwd_ok_reg && fwd_lvl_reg == upd_lvl_reg) ? fwd_val_reg : rd_data;
    assign bin_inc  = (bin_now == BIN_MAX) ? bin_now : bin_now + 1'b1;
    assign prod     = SUM_W'(rd_data) * SUM_W'(rd_lvl_reg);

    always_comb begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        lvl_next    = lvl_reg;
        low_next    = low_reg;
        high_next   = high_reg;
        seen_next   = seen_reg;
        stable_next = stable_reg;
        dmean_next  = dmean_reg;
        pass_next   = pass_reg;
        dsum_next   = dsum_reg;
        bsum_next   = bsum_reg;
        dcnt_next   = dcnt_reg;
        bcnt_next   = bcnt_reg;
        rd_ok_next  = 1'b0;
        rd_lvl_next = rd_lvl_reg;
        mvalid_next = mvalid_reg && !m_tready;
        mthr_next   = mthr_reg;
        mconv_next  = mconv_reg;
        upd_next    = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = upd_lvl_reg;
        wr_data     = bin_inc;
        rd_addr     = s_tdata;
        dreq.start    = 1'b0;
        dreq.dividend = dsum_reg;
        dreq.divisor  = dcnt_reg;

        // Pending increment from the previous pixel.
        if (upd_reg) begin
            wr_en = 1'b1;
        end

        case (state_reg)
            ST_CLEAR, ST_FLUSH: begin
                if (!upd_reg) begin
                    wr_en   = 1'b1;
                    wr_addr = idx_reg[LEVEL_W-1:0];
                    wr_data = '0;
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg[LEVEL_W]) begin
                        wr_en     = 1'b0;
                        idx_next  = '0;
                        state_next = ST_IDLE;
                    end else if (idx_reg == (LEVEL_W+1)'(LEVELS - 1)) begin
                        idx_next   = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_IDLE: begin
                if (take) begin
                    upd_next = 1'b1;
                    if (s_tlast) begin
                        state_next = ST_SCAN;
                        idx_next   = '0;
                        seen_next  = 1'b0;
                    end
                end
            end
            ST_SCAN: begin
                // Sweep reads 0..255; data arrives in the cycle after its address.
                if (!upd_reg) begin
                    rd_addr     = idx_reg[LEVEL_W-1:0];
                    rd_ok_next  = !idx_reg[LEVEL_W];
                    rd_lvl_next = idx_reg[LEVEL_W-1:0];
                    if (!idx_reg[LEVEL_W]) begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                if (rd_ok_reg && rd_data != '0) begin
                    if (!seen_reg) begin
                        low_next = rd_lvl_reg;
                    end
                    high_next = rd_lvl_reg;
                    seen_next = 1'b1;
                end
                if (idx_reg[LEVEL_W] && !rd_ok_reg) begin
                    pass_next = '0;
                    if (low_reg == high_reg) begin
                        lvl_next    = low_reg;
                        stable_next = 1'b1;
                        state_next  = ST_OUT;
                    end else begin
                        lvl_next   = LEVEL_W'(({1'b0, low_reg} + {1'b0, high_reg}) >> 1);
                        state_next = ST_SUM;
                        idx_next   = '0;
                        dsum_next  = '0;
                        bsum_next  = '0;
                        dcnt_next  = '0;
                        bcnt_next  = '0;
                    end
                end
            end
            ST_SUM: begin
                rd_addr     = idx_reg[LEVEL_W-1:0];
                rd_ok_next  = !idx_reg[LEVEL_W];
                rd_lvl_next = idx_reg[LEVEL_W-1:0];
                if (!idx_reg[LEVEL_W]) begin
                    idx_next = idx_reg + 1'b1;
                end
                if (rd_ok_reg) begin
                    if (rd_lvl_reg <= lvl_reg) begin
                        dsum_next = dsum_reg + prod;
                        dcnt_next = dcnt_reg + CNT_W'(rd_data);
                    end else begin
                        bsum_next = bsum_reg + prod;
                        bcnt_next = bcnt_reg + CNT_W'(rd_data);
                    end
                end
                if (idx_reg[LEVEL_W] && !rd_ok_reg) begin
                    state_next = ST_DIVD;
                end
            end
            ST_DIVD: begin
                dreq.start = 1'b1;
                state_next = ST_WAITD;
            end
            ST_WAITD: begin
                dreq.dividend = bsum_reg;
                dreq.divisor  = bcnt_reg;
                if (drsp.done) begin
                    dmean_next = (dcnt_reg == '0) ? '0 : drsp.quotient;
                    dreq.start = 1'b1;
                    state_next = ST_WAITB;
                end
            end
            ST_WAITB: begin
                if (drsp.done) begin
                    lvl_next = LEVEL_W'(({1'b0, dmean_reg} +
                               {1'b0, (bcnt_reg == '0) ? {LEVEL_W{1'b0}} : drsp.quotient})
                               >> 1);
                    pass_next  = pass_reg + 1'b1;
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT: begin
                // lvl_reg is new: compare with old via low_reg
                if (lvl_reg == low_reg) begin
                    stable_next = 1'b1;
                    state_next  = ST_OUT;
                end else if (pass_reg == PASS_W'(MAX_PASSES)) begin
                    stable_next = 1'b0;
                    state_next  = ST_OUT;
                end else begin
                    state_next = ST_SUM;
                    idx_next   = '0;
                    dsum_next  = '0;
                    bsum_next  = '0;
                    dcnt_next  = '0;
                    bcnt_next  = '0;
                end
                low_next = lvl_reg;
            end
            ST_OUT: begin
                if (!mvalid_reg || m_tready) begin
                    mvalid_next = 1'b1;
                    mthr_next   = lvl_reg;
                    mconv_next  = stable_reg;
                    idx_next    = '0;
                    state_next  = ST_FLUSH;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase

        // Remember the level in force before each pass for the stability check.
        if (state_reg == ST_DIVD) begin
            low_next = lvl_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_CLEAR;
            idx_reg    <= '0;
            upd_reg    <= 1'b0;
            rd_ok_reg  <= 1'b0;
            mvalid_reg <= 1'b0;
            fwd_ok_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            upd_reg    <= upd_next;
            rd_ok_reg  <= rd_ok_next;
            mvalid_reg <= mvalid_next;
            fwd_ok_reg <= wr_en;
        end
        fwd_val_reg <= wr_data;
        fwd_lvl_reg <= wr_addr;
        if (take) begin
            upd_lvl_reg <= s_tdata;
        end
        lvl_reg    <= lvl_next;
        low_reg    <= low_next;
        high_reg   <= high_next;
        seen_reg   <= seen_next;
        stable_reg <= stable_next;
        dmean_reg  <= dmean_next;
        pass_reg   <= pass_next;
        dsum_reg   <= dsum_next;
        bsum_reg   <= bsum_next;
        dcnt_reg   <= dcnt_next;
        bcnt_reg   <= bcnt_next;
        rd_lvl_reg <= rd_lvl_next;
        mthr_reg   <= mthr_next;
        mconv_reg  <= mconv_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mthr_reg;
    assign m_tuser  = mconv_reg;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    import hit_pkg::*;

    // One pixel item plus a flag that makes the sender wait for all results.
    typedef struct {
        logic [7:0] pixel;
        logic       last;
        bit         drain_first;
    } pixel_item_t;

    typedef struct {
        logic [7:0] threshold;
        logic       converged;
    } level_result_t;

    localparam int MAX_PASS_CNT = 256;
    localparam int SETTLE_CYCLES = 800;
    localparam int HOLDOFF_CYCLES = 4000;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = '0;   // pixel[7:0]
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;        // threshold[7:0]
    logic       m_tuser;        // converged

    pixel_item_t   pending_pixels[$];
    level_result_t expected_levels[$];
    logic [BIN_W-1:0] model_bins[LEVELS];
    int unsigned failures = 0;
    int unsigned pixels_taken = 0;
    int unsigned pixels_total = 0;
    int unsigned levels_seen = 0;
    int unsigned holdoff_left = 0;
    bit holdoff_done = 1'b0;

    histogram_isodata_threshold dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Clock with a 4 ns period.
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Floored mean of the levels on one side of the split level.
    function automatic logic [7:0] side_mean(input int split, input bit bright);
        longint wsum;
        longint cnt;
        wsum = 0;
        cnt = 0;
        for (int i = 0; i < LEVELS; i++) begin
            if ((i > split) == bright) begin
                wsum += longint'(i) * longint'(model_bins[i]);
                cnt += longint'(model_bins[i]);
            end
        end
        return (cnt == 0) ? 8'd0 : 8'(wsum / cnt);
    endfunction

    // Iterative intersection level of the histogram, then clear it.
    function automatic level_result_t isodata_level();
        level_result_t r;
        int lo;
        int hi;
        int cur;
        int prev;
        lo = -1;
        hi = 0;
        for (int i = 0; i < LEVELS; i++) begin
            if (model_bins[i] != 0) begin
                if (lo < 0) lo = i;
                hi = i;
            end
        end
        if (lo < 0) lo = 0;
        r.converged = 1'b0;
        if (lo == hi) begin
            cur = lo;
            r.converged = 1'b1;
        end else begin
            cur = (lo + hi) >> 1;
            for (int p = 0; p < MAX_PASS_CNT; p++) begin
                prev = cur;
                cur = (int'(side_mean(prev, 1'b0)) + int'(side_mean(prev, 1'b1))) >> 1;
                if (cur == prev) begin
                    r.converged = 1'b1;
                    break;
                end
            end
        end
        r.threshold = 8'(cur);
        for (int i = 0; i < LEVELS; i++) model_bins[i] = '0;
        return r;
    endfunction

    // Count one accepted pixel and predict the level on the last one.
    task automatic count_pixel(input logic [7:0] pix, input logic last);
        if (model_bins[pix] != BIN_MAX) model_bins[pix] = model_bins[pix] + 1'b1;
        if (last) expected_levels.push_back(isodata_level());
    endtask

    task automatic add_pixel(input logic [7:0] pix, input logic last, input bit drain = 1'b0);
        pixel_item_t it;
        it.pixel = pix;
        it.last = last;
        it.drain_first = drain;
        pending_pixels.push_back(it);
    endtask

    // One frame of random content; the shape decides how the levels cluster.
    task automatic add_random_frame(input bit drain);
        int len;
        int shape;
        int a;
        int b;
        logic [7:0] pix;
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 10);
        shape = $urandom_range(0, 3);
        a = $urandom_range(0, 255);
        b = $urandom_range(0, 255);
        for (int k = 0; k < len; k++) begin
            case (shape)
                0: pix = 8'($urandom);
                1: pix = 8'(a);
                2: pix = ($urandom_range(0, 1) != 0) ? 8'(a) : 8'(b);
                default: pix = 8'(a + $urandom_range(0, 7));
            endcase
            add_pixel(pix, k == len - 1, drain && k == 0);
        end
    endtask

    function automatic int idle_pct(input bit sender);
        if (pixels_taken < pixels_total / 3) return sender ? 37 : 74;
        if (pixels_taken < 2 * pixels_total / 3) return sender ? 74 : 37;
        return 0;
    endfunction

    // Sender: hold an offered item until it is taken, otherwise maybe idle.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                count_pixel(s_tdata, s_tlast);
                pixels_taken++;
            end
            if (!(s_tvalid && !s_tready)) begin
                if (pending_pixels.size() != 0
                        && !(pending_pixels[0].drain_first && expected_levels.size() != 0)
                        && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= pending_pixels[0].pixel;
                    s_tlast <= pending_pixels[0].last;
                    void'(pending_pixels.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each result item and stall at random or for a long hold-off.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                levels_seen++;
                if (expected_levels.size() == 0) begin
                    $display("%0t: unexpected result threshold=%0d converged=%0b",
                             $time, m_tdata, m_tuser);
                    failures++;
                end else begin
                    if (m_tdata !== expected_levels[0].threshold) begin
                        $display("%0t: threshold expected %0d actual %0d",
                                 $time, expected_levels[0].threshold, m_tdata);
                        failures++;
                    end
                    if (m_tuser !== expected_levels[0].converged) begin
                        $display("%0t: converged expected %0b actual %0b",
                                 $time, expected_levels[0].converged, m_tuser);
                        failures++;
                    end
                    void'(expected_levels.pop_front());
                end
            end
            if (!holdoff_done && levels_seen == 30) begin
                holdoff_done <= 1'b1;
                holdoff_left <= HOLDOFF_CYCLES;
                m_tready <= 1'b0;
            end else if (holdoff_left != 0) begin
                holdoff_left <= holdoff_left - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= idle_pct(1'b0));
            end
        end
    end

    // Stimulus, reset and the end of the run.
    initial begin
        for (int i = 0; i < LEVELS; i++) model_bins[i] = '0;
        // Single pixel at each extreme, then the two extremes together.
        add_pixel(8'd0, 1'b1);
        add_pixel(8'd255, 1'b1);
        add_pixel(8'd0, 1'b0);
        add_pixel(8'd255, 1'b1);
        // Single occupied level repeated.
        add_pixel(8'd128, 1'b0);
        add_pixel(8'd128, 1'b0);
        add_pixel(8'd128, 1'b1);
        // Two neighbouring levels and a lopsided frame.
        add_pixel(8'd7, 1'b0);
        add_pixel(8'd8, 1'b1);
        add_pixel(8'd1, 1'b0);
        add_pixel(8'd1, 1'b0);
        add_pixel(8'd1, 1'b0);
        add_pixel(8'd254, 1'b1);
        // Three clusters, the last pixel of the frame at a new level.
        add_pixel(8'd10, 1'b0);
        add_pixel(8'd12, 1'b0);
        add_pixel(8'd100, 1'b0);
        add_pixel(8'd101, 1'b0);
        add_pixel(8'd200, 1'b0);
        add_pixel(8'd85, 1'b1);
        for (int f = 0; pending_pixels.size() < 420; f++)
            add_random_frame(f == 0 || f == 30);
        pixels_total = pending_pixels.size();

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        wait (pending_pixels.size() == 0 && !s_tvalid);
        wait (expected_levels.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (failures == 0 && expected_levels.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Overall time limit.
    initial begin
        #200ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule
